/* src/bphd_pkg.sv */
// Package for the button press-and-hold detector.
// Holds default widths, reset values, command codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package bphd_pkg;

    // default widths
    localparam int BUTTON_BITS_DEFAULT = 8;
    localparam int TIMER_BITS_DEFAULT  = 16;

    // threshold reset values, in ticks
    localparam int LONG_THRESHOLD_RESET      = 2000;
    localparam int VERY_LONG_THRESHOLD_RESET = 5000;

    // item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    localparam cfg_index_t REG_BUTTON_MASK         = 2'd0;
    localparam cfg_index_t REG_LONG_THRESHOLD      = 2'd1;
    localparam cfg_index_t REG_VERY_LONG_THRESHOLD = 2'd2;

endpackage

/* src/button_press_and_hold_detector_unit.sv */
// Top level of the button press-and-hold detector.
// Depends on bphd_pkg for defaults, command codes and register indexes.
`timescale 1ns / 1ps

// Usage:
// - input channel (in_valid / in_stall): each item is a port sample
//   (command = sample, port_value active low) or a one millisecond tick
// - output channel (out_valid / out_stall): one result item per input item,
//   carrying pressed bits, press and release edges and the long and very long
//   press pulses
// - configuration: cfg_we writes cfg_wdata to register cfg_index
//   (button mask, long threshold, very long threshold) while the block is idle
// - latency: the result of an item is valid in the cycle after it is accepted
// - throughput: one item per cycle unless stalled; each item takes one pass of
//   combinational logic into the state registers, which also hold the result
// - stall: while a result waits under out_stall, in_stall is high and the
//   result and state hold; an item is taken in the same cycle the waiting
//   result leaves
// - reset: all flags and the hold timer clear, the mask clears (no buttons)
//   and the thresholds return to 2000 and 5000 ticks

module button_press_and_hold_detector_unit
    import bphd_pkg::*;
#(
    parameter int BUTTON_BITS = BUTTON_BITS_DEFAULT,
    parameter int TIMER_BITS  = TIMER_BITS_DEFAULT,
    localparam int CFG_BITS   = (TIMER_BITS > BUTTON_BITS) ? TIMER_BITS : BUTTON_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   command,
    input  logic [BUTTON_BITS-1:0] port_value,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [BUTTON_BITS-1:0] pressed,
    output logic [BUTTON_BITS-1:0] press_edges,
    output logic [BUTTON_BITS-1:0] release_edges,
    output logic [BUTTON_BITS-1:0] long_press,
    output logic [BUTTON_BITS-1:0] very_long_press,

    input  logic                   cfg_we,
    input  cfg_index_t             cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_wdata
);

    localparam logic [TIMER_BITS-1:0] TimerMax = '1;

    // configuration registers
    logic [BUTTON_BITS-1:0] button_mask_reg;
    logic [TIMER_BITS-1:0]  long_threshold_reg;
    logic [TIMER_BITS-1:0]  very_long_threshold_reg;

    // detector state, also the result register
    logic [BUTTON_BITS-1:0] pressed_bits_reg,    pressed_bits_next;
    logic [TIMER_BITS-1:0]  hold_ticks_reg,      hold_ticks_next;
    logic [BUTTON_BITS-1:0] down_pulse_reg,      down_pulse_next;
    logic [BUTTON_BITS-1:0] up_pulse_reg,        up_pulse_next;
    logic [BUTTON_BITS-1:0] long_pulse_reg,      long_pulse_next;
    logic                   long_fired_reg,      long_fired_next;
    logic [BUTTON_BITS-1:0] very_long_pulse_reg, very_long_pulse_next;
    logic                   very_long_fired_reg, very_long_fired_next;
    logic                   out_valid_reg,       out_valid_next;

    logic                   in_accept;
    logic                   out_accept;
    logic [BUTTON_BITS-1:0] sample_bits;
    logic [BUTTON_BITS-1:0] sample_diff;

    // handshake
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_mask_reg         <= '0;
            long_threshold_reg      <= TIMER_BITS'(LONG_THRESHOLD_RESET);
            very_long_threshold_reg <= TIMER_BITS'(VERY_LONG_THRESHOLD_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BUTTON_MASK:
                    button_mask_reg <= cfg_wdata[BUTTON_BITS-1:0];
                REG_LONG_THRESHOLD:
                    long_threshold_reg <= cfg_wdata[TIMER_BITS-1:0];
                REG_VERY_LONG_THRESHOLD:
                    very_long_threshold_reg <= cfg_wdata[TIMER_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // masked pressed bits and edges of a sample
    assign sample_bits = ~port_value & button_mask_reg;
    assign sample_diff = sample_bits ^ pressed_bits_reg;

    // next state for one item
    always_comb
    begin
        pressed_bits_next    = pressed_bits_reg;
        hold_ticks_next      = hold_ticks_reg;
        down_pulse_next      = down_pulse_reg;
        up_pulse_next        = up_pulse_reg;
        long_pulse_next      = long_pulse_reg;
        long_fired_next      = long_fired_reg;
        very_long_pulse_next = very_long_pulse_reg;
        very_long_fired_next = very_long_fired_reg;

        if (command == CMD_TICK)
        begin
            // saturating hold timer
            if (hold_ticks_reg != TimerMax)
                hold_ticks_next = hold_ticks_reg + 1'b1;
        end
        else
        begin
            pressed_bits_next = sample_bits;
            down_pulse_next   = sample_diff & sample_bits;
            up_pulse_next     = sample_diff & pressed_bits_reg;

            if (sample_bits == '0)
            begin
                // nothing held: clear timer and re-arm
                hold_ticks_next      = '0;
                long_pulse_next      = '0;
                long_fired_next      = 1'b0;
                very_long_pulse_next = '0;
                very_long_fired_next = 1'b0;
            end
            else if (hold_ticks_reg >= very_long_threshold_reg)
            begin
                // very long hold, fires once
                long_pulse_next = '0;
                if (!very_long_fired_reg)
                begin
                    very_long_fired_next = 1'b1;
                    very_long_pulse_next = sample_bits;
                end
                else
                begin
                    very_long_pulse_next = '0;
                end
            end
            else if (hold_ticks_reg >= long_threshold_reg)
            begin
                // long hold, fires once
                if (!long_fired_reg)
                begin
                    long_fired_next = 1'b1;
                    long_pulse_next = sample_bits;
                end
                else
                begin
                    long_pulse_next = '0;
                end
            end
            else
            begin
                // below long threshold: re-arm both
                long_pulse_next      = '0;
                long_fired_next      = 1'b0;
                very_long_pulse_next = '0;
                very_long_fired_next = 1'b0;
            end
        end
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
            out_valid_next = 1'b1;
        else if (out_accept)
            out_valid_next = 1'b0;
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_bits_reg    <= '0;
            hold_ticks_reg      <= '0;
            down_pulse_reg      <= '0;
            up_pulse_reg        <= '0;
            long_pulse_reg      <= '0;
            long_fired_reg      <= 1'b0;
            very_long_pulse_reg <= '0;
            very_long_fired_reg <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                pressed_bits_reg    <= pressed_bits_next;
                hold_ticks_reg      <= hold_ticks_next;
                down_pulse_reg      <= down_pulse_next;
                up_pulse_reg        <= up_pulse_next;
                long_pulse_reg      <= long_pulse_next;
                long_fired_reg      <= long_fired_next;
                very_long_pulse_reg <= very_long_pulse_next;
                very_long_fired_reg <= very_long_fired_next;
            end
        end
    end

    // result item
    assign out_valid       = out_valid_reg;
    assign pressed         = pressed_bits_reg;
    assign press_edges     = down_pulse_reg;
    assign release_edges   = up_pulse_reg;
    assign long_press      = long_pulse_reg;
    assign very_long_press = very_long_pulse_reg;

endmodule

/* dv/button_press_and_hold_detector_unit_test.sv */
// Self-checking testbench for button_press_and_hold_detector_unit: a directed table and
// randomized hold sequences, checked against typed table values or a local predictor.
// Depends on bphd_pkg and the detector RTL only.
`timescale 1ns / 1ps

module button_press_and_hold_detector_unit_test;

    import bphd_pkg::*;

    typedef struct packed {
        logic [7:0] pressed;
        logic [7:0] press_edges;
        logic [7:0] release_edges;
        logic [7:0] long_press;
        logic [7:0] very_long_press;
    } flags_t;

    typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_t;

    // one row of the directed table: an item, or a full register setup
    typedef struct packed {
        row_kind_t   kind;
        logic        cmd;
        logic [7:0]  port;
        logic        typed;
        flags_t      want;
        logic [7:0]  mask;
        logic [15:0] long_thr;
        logic [15:0] very_long_thr;
    } step_t;

    localparam int QUIET_LIMIT = 2000;

    localparam step_t STEPS [25] = '{
        '{ROW_ITEM, CMD_SAMPLE, 8'h00, 1'b1, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_TICK,   8'h00, 1'b1, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_CFG,  CMD_SAMPLE, 8'h00, 1'b0, '0, 8'hFF, 16'd2, 16'd4},
        '{ROW_ITEM, CMD_SAMPLE, 8'hFF, 1'b1, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_SAMPLE, 8'h00, 1'b1, '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00},
          8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_TICK,   8'h00, 1'b0, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_TICK,   8'h00, 1'b0, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_SAMPLE, 8'h00, 1'b1, '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00},
          8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_SAMPLE, 8'h00, 1'b0, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_TICK,   8'h00, 1'b0, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_TICK,   8'h00, 1'b0, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_SAMPLE, 8'h00, 1'b1, '{8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF},
          8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_SAMPLE, 8'h00, 1'b0, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_SAMPLE, 8'h5A, 1'b1, '{8'hA5, 8'h00, 8'h5A, 8'h00, 8'h00},
          8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_SAMPLE, 8'hFF, 1'b1, '{8'h00, 8'h00, 8'hA5, 8'h00, 8'h00},
          8'h00, 16'd0, 16'd0},
        '{ROW_CFG,  CMD_SAMPLE, 8'h00, 1'b0, '0, 8'h3C, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_SAMPLE, 8'h00, 1'b1, '{8'h3C, 8'h3C, 8'h00, 8'h00, 8'h3C},
          8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_SAMPLE, 8'h00, 1'b0, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_TICK,   8'h00, 1'b0, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_CFG,  CMD_SAMPLE, 8'h00, 1'b0, '0, 8'hFF, 16'd0, 16'd3},
        '{ROW_ITEM, CMD_SAMPLE, 8'hFE, 1'b0, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_TICK,   8'h00, 1'b0, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_TICK,   8'h00, 1'b0, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_SAMPLE, 8'hFE, 1'b0, '0, 8'h00, 16'd0, 16'd0},
        '{ROW_ITEM, CMD_SAMPLE, 8'h7F, 1'b0, '0, 8'h00, 16'd0, 16'd0}
    };

    localparam string FIELD_NAMES [5] = '{
        "very_long_press", "long_press", "release_edges", "press_edges", "pressed"
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        command = CMD_SAMPLE;
    logic [7:0]  port_value = 8'h00;
    logic        out_stall = 1'b0;
    logic        cfg_we = 1'b0;
    cfg_index_t  cfg_index = REG_BUTTON_MASK;
    logic [15:0] cfg_wdata = 16'h0000;

    logic        in_stall;
    logic        out_valid;
    logic [7:0]  pressed;
    logic [7:0]  press_edges;
    logic [7:0]  release_edges;
    logic [7:0]  long_press;
    logic [7:0]  very_long_press;

    button_press_and_hold_detector_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .port_value      (port_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pressed         (pressed),
        .press_edges     (press_edges),
        .release_edges   (release_edges),
        .long_press      (long_press),
        .very_long_press (very_long_press),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #1 clk = ~clk;

    // predictor copy of the registers and detector state
    logic [7:0]  exp_mask = 8'h00;
    logic [15:0] exp_long_thr = 16'd2000;
    logic [15:0] exp_very_long_thr = 16'd5000;
    logic [7:0]  exp_pressed = 8'h00;
    logic [7:0]  exp_down = 8'h00;
    logic [7:0]  exp_up = 8'h00;
    logic [7:0]  exp_long = 8'h00;
    logic [7:0]  exp_very_long = 8'h00;
    logic [15:0] exp_hold = 16'h0000;
    logic        exp_long_fired = 1'b0;
    logic        exp_very_long_fired = 1'b0;

    flags_t pending_flags [$];
    flags_t seen_flags;
    flags_t oldest_flags;
    int     errors = 0;
    int     quiet_cycles = 0;
    int     stall_left = 0;
    logic   throttle = 1'b0;

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        errors++;
    endtask

    // apply one item to the predicted detector state, return its flags
    task automatic advance_detector(input logic cmd, input logic [7:0] port,
                                    output flags_t flags);
        logic [7:0] prev;
        prev = exp_pressed;
        if (cmd == CMD_TICK)
        begin
            if (exp_hold != 16'hFFFF)
                exp_hold = exp_hold + 16'd1;
        end
        else
        begin
            exp_pressed = ~port & exp_mask;
            exp_down = (exp_pressed ^ prev) & exp_pressed;
            exp_up = (exp_pressed ^ prev) & prev;
            if (exp_pressed == 8'h00)
                exp_hold = 16'h0000;
            // very long threshold wins and always drops the long pulse
            if (exp_pressed != 8'h00 && exp_hold >= exp_very_long_thr)
            begin
                exp_long = 8'h00;
                exp_very_long = exp_very_long_fired ? 8'h00 : exp_pressed;
                exp_very_long_fired = 1'b1;
            end
            else if (exp_pressed != 8'h00 && exp_hold >= exp_long_thr)
            begin
                exp_long = exp_long_fired ? 8'h00 : exp_pressed;
                exp_long_fired = 1'b1;
            end
            else
            begin
                exp_long = 8'h00;
                exp_long_fired = 1'b0;
                exp_very_long = 8'h00;
                exp_very_long_fired = 1'b0;
            end
        end
        flags = '{exp_pressed, exp_down, exp_up, exp_long, exp_very_long};
    endtask

    // present one item, wait for it to be taken, record what it should return
    task automatic offer_item(input logic cmd, input logic [7:0] port,
                              input logic typed, input flags_t want);
        flags_t flags;
        if (throttle && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        port_value <= port;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_detector(cmd, port, flags);
        pending_flags.push_back(typed ? want : flags);
    endtask

    // drain the block, then write all three registers
    task automatic apply_setup(input logic [7:0] mask, input logic [15:0] long_thr,
                               input logic [15:0] very_long_thr);
        in_valid <= 1'b0;
        while (pending_flags.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_BUTTON_MASK;
        cfg_wdata <= {8'($urandom), mask};
        @(posedge clk);
        cfg_index <= REG_LONG_THRESHOLD;
        cfg_wdata <= long_thr;
        @(posedge clk);
        cfg_index <= REG_VERY_LONG_THRESHOLD;
        cfg_wdata <= very_long_thr;
        @(posedge clk);
        cfg_we <= 1'b0;
        exp_mask = mask;
        exp_long_thr = long_thr;
        exp_very_long_thr = very_long_thr;
    endtask

    // result checking, output stall bursts and the no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen_flags = '{pressed, press_edges, release_edges, long_press,
                               very_long_press};
                if (pending_flags.size() == 0)
                    report_mismatch($sformatf("result %010h with none expected", seen_flags));
                else
                begin
                    oldest_flags = pending_flags.pop_front();
                    for (int i = 0; i < 5; i++)
                    begin
                        if (seen_flags[i*8 +: 8] !== oldest_flags[i*8 +: 8])
                            report_mismatch($sformatf("%s expected %02h got %02h",
                                FIELD_NAMES[i], oldest_flags[i*8 +: 8],
                                seen_flags[i*8 +: 8]));
                    end
                end
            end

            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (throttle && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;

            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int          pick;
        logic        cmd;
        logic [7:0]  port;
        logic [7:0]  held;
        logic [7:0]  mask;
        logic [15:0] long_thr;
        logic [15:0] very_long_thr;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, starting from reset settings
        throttle <= 1'b1;
        foreach (STEPS[i])
        begin
            if (STEPS[i].kind == ROW_CFG)
                apply_setup(STEPS[i].mask, STEPS[i].long_thr, STEPS[i].very_long_thr);
            else
                offer_item(STEPS[i].cmd, STEPS[i].port, STEPS[i].typed, STEPS[i].want);
        end

        // random press and hold sequences under varied settings
        for (int phase = 0; phase < 12; phase++)
        begin
            mask = 8'($urandom);
            long_thr = 16'($urandom_range(0, 16));
            very_long_thr = 16'($urandom_range(0, 30));
            case (phase)
                0: mask = 8'hFF;
                1: mask = 8'h00;
                2: very_long_thr = 16'hFFFF;
                3: long_thr = 16'hFFFF;
                4:
                begin
                    mask = 8'hFF;
                    long_thr = 16'hFFFF;
                    very_long_thr = 16'hFFFF;
                end
                5:
                begin
                    long_thr = 16'd0;
                    very_long_thr = 16'd0;
                end
                default: ;
            endcase
            apply_setup(mask, long_thr, very_long_thr);
            held = 8'($urandom);
            for (int n = 0; n < 150; n++)
            begin
                if (n % 50 == 0)
                    throttle <= (phase != 11) && ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    cmd = CMD_TICK;
                    port = 8'($urandom);
                end
                else
                begin
                    cmd = CMD_SAMPLE;
                    if (pick >= 98)
                        held = 8'hFF;
                    else if (pick >= 92)
                        held = 8'($urandom);
                    else if (pick >= 82)
                        held = held ^ (8'h01 << $urandom_range(0, 7));
                    port = held;
                end
                offer_item(cmd, port, 1'b0, '0);
            end
        end

        // drain and finish
        in_valid <= 1'b0;
        while (pending_flags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* button_press_and_hold_detector_unit.f */
src/bphd_pkg.sv
src/button_press_and_hold_detector_unit.sv
dv/button_press_and_hold_detector_unit_test.sv
